// File: hdl/first_fit_row_allocator_defines.svh
// Assertion helpers shared by the allocator RTL.
`ifndef FIRST_FIT_ROW_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_ROW_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define FRA_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("fra assertion failed");

// Next-cycle implication, disabled in reset.
`define FRA_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("fra assertion failed");

`endif

// File: hdl/fra_pkg.sv
package fra_pkg;

  localparam int MAX_RUNS   = 64;
  localparam int IDX_W      = $clog2(MAX_RUNS);
  localparam int CNT_W      = $clog2(MAX_RUNS + 1);
  localparam int ROW_SHIFT  = 15;
  localparam int TOTAL_ROWS = 131072;
  localparam int START_W    = 17;
  localparam int LEN_W      = 18;
  localparam int WANT_W     = LEN_W + 1;
  localparam logic [33:0] SPACE_BYTES = 34'(TOTAL_ROWS) << ROW_SHIFT;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_ZERO     = 3'd1,
    ST_NOSPACE  = 3'd2,
    ST_MISALIGN = 3'd3,
    ST_RANGE    = 3'd4,
    ST_OVERLAP  = 3'd5,
    ST_FULL     = 3'd6
  } status_t;

endpackage

// File: hdl/fra_ram.sv
module fra_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/first_fit_row_allocator.sv
// Channel   Dir  tdata (low bit up)                                         tuser
// s_axis    in   offset_bytes[31:0], length_bytes[64:32], pad               opcode
// m_axis    out  granted_offset, granted_size, used_bytes, free_bytes,      status
//                largest_run_bytes, pad
//
// One item at a time, through a run memory with one write and one read port:
// first-fit or ordered scan, then an entry shift for an insert or remove, then
// a statistics pass over all runs.
// After rst the S_INIT state writes the initial run before s_axis_tready rises.
// A pending result does not block the next transfer; a stalled m_axis holds the
// next result in its final state.
module first_fit_row_allocator (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [71:0]  s_axis_tdata,  // offset_bytes[31:0], length_bytes[64:32]
  input  logic         s_axis_tuser,  // opcode
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [167:0] m_axis_tdata,  // granted_offset, granted_size, used, free, largest
  output logic [2:0]   m_axis_tuser   // status
);
  import fra_pkg::*;
  `include "first_fit_row_allocator_defines.svh"

  typedef enum logic [4:0] {
    S_INIT, S_IDLE,
    S_A_RD, S_A_CHK,
    S_F_RD, S_F_CHK, S_F_DEC,
    S_UP_RD, S_UP_WR, S_INS,
    S_RM_RD, S_RM_WR,
    S_ST0, S_ST_RD, S_ST_ACC, S_OUT
  } state_t;

  state_t state;
  logic [CNT_W-1:0]   idx, pos, count;
  logic [LEN_W-1:0]   used, sum, maxl;
  logic [WANT_W-1:0]  want, fend;
  logic [START_W-1:0] first;
  logic               has_next, rm_dec;
  entry_t             prev_e, next_e;
  status_t            status;
  logic [31:0]        goff;
  logic [32:0]        gsize;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  entry_t             ram_wdata, rd;
  logic [ENTRY_W-1:0] ram_rdata;

  fra_ram #(.DATA_W(ENTRY_W), .DEPTH(MAX_RUNS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = entry_t'(ram_rdata);

  logic [31:0]        in_off;
  logic [32:0]        in_len;
  logic [33:0]        in_end;
  logic [WANT_W-1:0]  in_want;
  logic [WANT_W-1:0]  prev_end, rd_end;
  logic               merge_prev, merge_next;

  assign in_off   = s_axis_tdata[31:0];
  assign in_len   = s_axis_tdata[64:32];
  assign in_end   = {2'b0, in_off} + {1'b0, in_len};
  assign in_want  = WANT_W'(in_len[32:ROW_SHIFT]) + WANT_W'(in_len[ROW_SHIFT-1:0] != '0);
  assign prev_end = WANT_W'(prev_e.start) + WANT_W'(prev_e.len);
  assign rd_end   = WANT_W'(rd.start) + WANT_W'(rd.len);
  assign merge_prev = (pos != '0) && (prev_end == WANT_W'(first));
  assign merge_next = has_next && (fend == WANT_W'(next_e.start));

  assign s_axis_tready = (state == S_IDLE);
  assign ram_raddr = (state == S_UP_RD) ? IDX_W'(idx - 1'b1) : idx[IDX_W-1:0];

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = idx[IDX_W-1:0];
    ram_wdata = rd;
    case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = '{start: '0, len: LEN_W'(TOTAL_ROWS)};
      end
      S_A_CHK: begin
        // shrink the run from its front on a partial fit
        ram_we    = ({1'b0, rd.len} > want);
        ram_wdata = '{start: START_W'(WANT_W'(rd.start) + want),
                      len: LEN_W'(WANT_W'(rd.len) - want)};
      end
      S_F_DEC: begin
        if (!(has_next && fend > WANT_W'(next_e.start)) && count < CNT_W'(MAX_RUNS)) begin
          if (merge_prev) begin
            ram_we    = 1'b1;
            ram_waddr = IDX_W'(pos - 1'b1);
            ram_wdata = '{start: prev_e.start,
                          len: prev_e.len + LEN_W'(want) + (merge_next ? next_e.len : '0)};
          end else if (merge_next) begin
            ram_we    = 1'b1;
            ram_waddr = pos[IDX_W-1:0];
            ram_wdata = '{start: first, len: LEN_W'(want) + next_e.len};
          end
        end
      end
      S_UP_WR: begin
        ram_we = 1'b1;
      end
      S_INS: begin
        ram_we    = 1'b1;
        ram_waddr = pos[IDX_W-1:0];
        ram_wdata = '{start: first, len: LEN_W'(want)};
      end
      S_RM_WR: begin
        ram_we    = 1'b1;
        ram_waddr = IDX_W'(idx - 1'b1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_INIT;
      count         <= CNT_W'(1);
      used          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tready && state != S_OUT) begin
        m_axis_tvalid <= 1'b0;
      end
      unique case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (s_axis_tvalid) begin
            goff   <= '0;
            gsize  <= '0;
            idx    <= '0;
            first  <= in_off[31:ROW_SHIFT];
            fend   <= WANT_W'(in_off[31:ROW_SHIFT]) + WANT_W'(in_len[32:ROW_SHIFT]);
            has_next <= 1'b0;
            if (!s_axis_tuser) begin
              want <= in_want;
              if (in_len == '0) begin
                status <= ST_ZERO;
                state  <= S_ST0;
              end else begin
                status <= ST_OK;
                state  <= S_A_RD;
              end
            end else begin
              want <= WANT_W'(in_len[32:ROW_SHIFT]);
              priority if (in_len == '0) begin
                status <= ST_OK;
                state  <= S_ST0;
              end else if (in_off[ROW_SHIFT-1:0] != '0 || in_len[ROW_SHIFT-1:0] != '0) begin
                status <= ST_MISALIGN;
                state  <= S_ST0;
              end else if (in_end > SPACE_BYTES) begin
                status <= ST_RANGE;
                state  <= S_ST0;
              end else begin
                status <= ST_OK;
                state  <= S_F_RD;
              end
            end
          end
        end
        S_A_RD: begin
          if (idx < count) begin
            state <= S_A_CHK;
          end else begin
            status <= ST_NOSPACE;
            state  <= S_ST0;
          end
        end
        S_A_CHK: begin
          if ({1'b0, rd.len} >= want) begin
            goff  <= {rd.start, {ROW_SHIFT{1'b0}}};
            gsize <= {want[LEN_W-1:0], {ROW_SHIFT{1'b0}}};
            used  <= used + LEN_W'(want);
            if ({1'b0, rd.len} == want) begin
              idx    <= idx + 1'b1;
              rm_dec <= 1'b1;
              state  <= S_RM_RD;
            end else begin
              state <= S_ST0;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_A_RD;
          end
        end
        S_F_RD: begin
          pos <= idx;
          if (idx < count) begin
            state <= S_F_CHK;
          end else begin
            state <= S_F_DEC;
          end
        end
        S_F_CHK: begin
          if (rd.start < first) begin
            if (rd_end > WANT_W'(first)) begin
              status <= ST_OVERLAP;
              state  <= S_ST0;
            end else begin
              prev_e <= rd;
              idx    <= idx + 1'b1;
              state  <= S_F_RD;
            end
          end else begin
            next_e   <= rd;
            has_next <= 1'b1;
            state    <= S_F_DEC;
          end
        end
        S_F_DEC: begin
          priority if (has_next && fend > WANT_W'(next_e.start)) begin
            status <= ST_OVERLAP;
            state  <= S_ST0;
          end else if (count >= CNT_W'(MAX_RUNS)) begin
            status <= ST_FULL;
            state  <= S_ST0;
          end else begin
            used <= (used > LEN_W'(want)) ? used - LEN_W'(want) : '0;
            if (merge_prev && merge_next) begin
              idx    <= pos + 1'b1;
              rm_dec <= 1'b1;
              state  <= S_RM_RD;
            end else if (merge_prev || merge_next) begin
              state <= S_ST0;
            end else begin
              idx   <= count;
              state <= S_UP_RD;
            end
          end
        end
        S_UP_RD: begin
          state <= (idx > pos) ? S_UP_WR : S_INS;
        end
        S_UP_WR: begin
          idx   <= idx - 1'b1;
          state <= S_UP_RD;
        end
        S_INS: begin
          count <= count + 1'b1;
          state <= S_ST0;
        end
        S_RM_RD: begin
          if (idx < count) begin
            state <= S_RM_WR;
          end else begin
            if (rm_dec) begin
              count <= count - 1'b1;
            end
            rm_dec <= 1'b0;
            state  <= S_ST0;
          end
        end
        S_RM_WR: begin
          idx   <= idx + 1'b1;
          state <= S_RM_RD;
        end
        S_ST0: begin
          idx   <= '0;
          sum   <= '0;
          maxl  <= '0;
          state <= S_ST_RD;
        end
        S_ST_RD: begin
          state <= (idx < count) ? S_ST_ACC : S_OUT;
        end
        S_ST_ACC: begin
          sum <= sum + rd.len;
          if (rd.len > maxl) begin
            maxl <= rd.len;
          end
          idx   <= idx + 1'b1;
          state <= S_ST_RD;
        end
        S_OUT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tuser  <= status;
            m_axis_tdata  <= {4'b0,
                              maxl, {ROW_SHIFT{1'b0}},
                              sum,  {ROW_SHIFT{1'b0}},
                              used, {ROW_SHIFT{1'b0}},
                              gsize, goff};
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  `FRA_ASSERT_IMP(a_count_max, clk, rst, 1'b1, count <= CNT_W'(MAX_RUNS))
  `FRA_ASSERT_NXT(a_busy_after_in, clk, rst, s_axis_tvalid && s_axis_tready, state != S_IDLE)
  `FRA_ASSERT_IMP(a_out_from_final, clk, rst, $rose(m_axis_tvalid), $past(state == S_OUT))
  `FRA_ASSERT_IMP(a_rows_conserved, clk, rst, state == S_OUT,
                  ({1'b0, used} + {1'b0, sum}) == WANT_W'(TOTAL_ROWS))

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fra_pkg::*;

  localparam longint ROW_SZ = 32768;
  localparam longint SPACE = ROW_SZ * TOTAL_ROWS;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM = 2000;

  typedef enum bit {OP_ALLOC = 1'b0, OP_FREE = 1'b1} op_e;

  typedef struct {
    status_t status;
    bit [31:0] goff;
    bit [32:0] gsize;
    bit [32:0] used;
    bit [32:0] free_b;
    bit [32:0] largest;
  } alloc_result_t;

  // Free-run table model plus queue of pending results.
  class alloc_scoreboard;
    longint run_start[$];
    longint run_len[$];
    longint used_rows;
    alloc_result_t pending[$];
    int mismatches;
    int checked;

    function void clear();
      run_start = {0};
      run_len = {TOTAL_ROWS};
      used_rows = 0;
    endfunction

    function status_t alloc_rows(longint len, ref alloc_result_t r);
      longint want;
      if (len == 0) return ST_ZERO;
      want = (len + ROW_SZ - 1) / ROW_SZ;
      foreach (run_len[i]) begin
        if (run_len[i] >= want) begin
          r.goff = 32'(run_start[i] * ROW_SZ);
          r.gsize = 33'(want * ROW_SZ);
          used_rows += want;
          if (run_len[i] == want) begin
            run_start.delete(i);
            run_len.delete(i);
          end else begin
            run_start[i] += want;
            run_len[i] -= want;
          end
          return ST_OK;
        end
      end
      return ST_NOSPACE;
    endfunction

    function status_t free_rows(longint off, longint len);
      longint first, rows, stop;
      int pos;
      if (len == 0) return ST_OK;
      if (off % ROW_SZ != 0 || len % ROW_SZ != 0) return ST_MISALIGN;
      if (off + len > SPACE) return ST_RANGE;
      first = off / ROW_SZ;
      rows = len / ROW_SZ;
      stop = first + rows;
      pos = 0;
      while (pos < run_start.size() && run_start[pos] < first) begin
        if (run_start[pos] + run_len[pos] > first) return ST_OVERLAP;
        pos++;
      end
      if (pos < run_start.size() && stop > run_start[pos]) return ST_OVERLAP;
      if (run_start.size() >= MAX_RUNS) return ST_FULL;
      run_start.insert(pos, first);
      run_len.insert(pos, rows);
      used_rows = (used_rows > rows) ? used_rows - rows : 0;
      if (pos + 1 < run_start.size() && run_start[pos] + run_len[pos] == run_start[pos+1]) begin
        run_len[pos] += run_len[pos+1];
        run_start.delete(pos + 1);
        run_len.delete(pos + 1);
      end
      if (pos > 0 && run_start[pos-1] + run_len[pos-1] == run_start[pos]) begin
        run_len[pos-1] += run_len[pos];
        run_start.delete(pos);
        run_len.delete(pos);
      end
      return ST_OK;
    endfunction

    function void note_input(bit op, bit [31:0] off, bit [32:0] len);
      alloc_result_t r;
      longint fsum, big;
      r.goff = '0;
      r.gsize = '0;
      if (op == OP_ALLOC) r.status = alloc_rows(len, r);
      else r.status = free_rows(off, len);
      fsum = 0;
      big = 0;
      foreach (run_len[i]) begin
        fsum += run_len[i];
        if (run_len[i] > big) big = run_len[i];
      end
      r.used = 33'(used_rows * ROW_SZ);
      r.free_b = 33'(fsum * ROW_SZ);
      r.largest = 33'(big * ROW_SZ);
      pending.push_back(r);
    endfunction

    function void check_result(bit [2:0] st, bit [167:0] d);
      alloc_result_t e;
      alloc_result_t a;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result transfer, status %0d", st);
        return;
      end
      e = pending.pop_front();
      checked++;
      a.status = status_t'(st);
      a.goff = d[31:0];
      a.gsize = d[64:32];
      a.used = d[97:65];
      a.free_b = d[130:98];
      a.largest = d[163:131];
      if (a.status != e.status || a.goff != e.goff || a.gsize != e.gsize ||
          a.used != e.used || a.free_b != e.free_b || a.largest != e.largest) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("ERROR: result %0d exp st=%0d off=%h sz=%h used=%h free=%h big=%h",
                   checked, e.status, e.goff, e.gsize, e.used, e.free_b, e.largest);
          $display("       got st=%0d off=%h sz=%h used=%h free=%h big=%h",
                   a.status, a.goff, a.gsize, a.used, a.free_b, a.largest);
        end
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic s_axis_tuser = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [167:0] m_axis_tdata;
  logic [2:0] m_axis_tuser;

  alloc_scoreboard sb;
  bit no_idle = 1'b0;
  int idle_pct = 29;
  int n_sent = 0;
  int n_alloc = 0;
  int n_free = 0;
  int quiet_cycles = 0;
  // Live allocations, kept for well-formed frees.
  longint live_off[$];
  longint live_len[$];

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  first_fit_row_allocator dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
  );

  // Result side: check at rising edge, change ready at falling edge.
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tuser, m_axis_tdata);
    if (!rst && ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  always @(negedge clk) begin
    m_axis_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("ERROR: watchdog, no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_item(bit op, bit [31:0] off, bit [32:0] len);
    @(negedge clk);
    while (!no_idle && $urandom_range(99) < idle_pct) @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, len, off};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(op, off, len);
    n_sent++;
    if (op == OP_ALLOC) n_alloc++;
    else n_free++;
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
  endtask

  // Allocate and remember the grant if the model says it succeeds.
  task automatic do_alloc(bit [32:0] len);
    send_item(OP_ALLOC, $urandom, len);
    if (sb.pending[$].status == ST_OK) begin
      live_off.push_back(sb.pending[$].goff);
      live_len.push_back(sb.pending[$].gsize);
    end
  endtask

  task automatic do_free_live(int k, bit part);
    longint o, l;
    o = live_off[k];
    l = live_len[k];
    live_off.delete(k);
    live_len.delete(k);
    // Optionally free only the tail rows; head stays live.
    if (part && l > ROW_SZ) begin
      longint keep;
      keep = ROW_SZ * $urandom_range(1, int'(l / ROW_SZ) - 1);
      live_off.push_back(o);
      live_len.push_back(keep);
      o += keep;
      l -= keep;
    end
    send_item(OP_FREE, 32'(o), 33'(l));
  endtask

  task automatic wait_drain();
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
  endtask

  function automatic bit [32:0] rand_len();
    case ($urandom_range(9))
      0: return {$urandom, 1'b0} | 33'($urandom_range(1));
      1: return 33'($urandom_range(1, 64));
      2, 3: return 33'(ROW_SZ * $urandom_range(1, 4));
      4: return 33'($urandom_range(1, 4 * 32768));
      5: return 33'(ROW_SZ * $urandom_range(1, 4096));
      6: return 33'(ROW_SZ * $urandom_range(1, 64)) - 33'($urandom_range(0, 100));
      default: return 33'($urandom_range(1, 8) * ROW_SZ);
    endcase
  endfunction

  initial begin
    int k;
    sb = new();
    sb.clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extremes and each error path.
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 33'd0);
    send_item(OP_FREE, 32'd0, 33'd0);
    do_alloc(33'd1);
    do_alloc(33'h1_0000_0000);
    do_alloc(33'd32768);
    send_item(OP_FREE, 32'd0, 33'd32768);
    send_item(OP_FREE, 32'd0, 33'd32768);
    send_item(OP_FREE, 32'd1, 33'd32768);
    send_item(OP_FREE, 32'd0, 33'd100);
    send_item(OP_FREE, 32'hFFFF_8000, 33'd65536);
    send_item(OP_FREE, 32'hFFFF_FFFF, 33'h1_FFFF_FFFF);
    send_item(OP_FREE, 32'd0, 33'h1_0000_0000);
    do_alloc(33'h1_FFFF_FFFF);
    for (int i = 0; i < 3 && live_off.size() > 0; i++) do_free_live(0, 1'b0);
    do_alloc(33'h1_0000_0000);
    while (live_off.size() > 0) do_free_live(0, 1'b0);
    // Fill the run table: many single-row grants, free every other one.
    for (int i = 0; i < 140; i++) do_alloc(33'd32768);
    for (int i = 0; i < 70 && i < live_off.size(); i++) do_free_live(i, 1'b0);
    send_item(OP_FREE, 32'(live_off[$]), 33'(live_len[$]));
    do_alloc(33'h1_0000_0000);
    wait_drain();

    // Random: mostly well-formed alloc/free, some noise. No idling for a stretch.
    for (int i = 0; i < N_RANDOM; i++) begin
      no_idle = (i >= 600 && i < 900);
      k = $urandom_range(99);
      if (k < 45 || live_off.size() == 0) do_alloc(rand_len());
      else if (k < 85) do_free_live($urandom_range(live_off.size() - 1), $urandom_range(3) == 0);
      else if (k < 92)
        send_item(OP_FREE, 32'(ROW_SZ * $urandom_range(0, TOTAL_ROWS - 1)),
                  33'(ROW_SZ * $urandom_range(1, 8)));
      else send_item(OP_FREE, $urandom, {$urandom, 1'b0} | 33'($urandom_range(1)));
      // Occasionally release all but 20 live grants to restore long runs.
      if (live_off.size() > 200)
        while (live_off.size() > 20) do_free_live($urandom_range(live_off.size() - 1), 1'b0);
    end

    wait_drain();
    $display("Sent %0d items (%0d allocate, %0d free), checked %0d results, %0d mismatches",
             n_sent, n_alloc, n_free, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
